// ===== hdl/dtp_pkg.sv =====
`timescale 1ns / 1ps

package dtp_pkg;

  localparam logic [1:0] CmdRun   = 2'd0;
  localparam logic [1:0] CmdRead  = 2'd1;
  localparam logic [1:0] CmdWrite = 2'd2;

  localparam logic [15:0] AddrDiv  = 16'hFF04;
  localparam logic [15:0] AddrTima = 16'hFF05;
  localparam logic [15:0] AddrTma  = 16'hFF06;
  localparam logic [15:0] AddrTac  = 16'hFF07;

  localparam logic [15:0] SysReset     = 16'hAB00;
  localparam logic [15:0] SysStep      = 16'd4;
  localparam logic [7:0]  UnmappedByte = 8'hFF;
  localparam logic [7:0]  TacUpperOnes = 8'hF8;

  typedef struct packed {
    logic load_item;
    logic step;
    logic do_bus;
    logic load_out;
  } dtp_cmd_t;

  typedef struct packed {
    logic is_run;
    logic cnt_zero;
    logic cnt_one;
  } dtp_status_t;

  function automatic logic sel_bit(logic [15:0] cnt, logic [1:0] sel);
    logic b;
    case (sel)
      2'd0: b = cnt[9];
      2'd1: b = cnt[3];
      2'd2: b = cnt[5];
      2'd3: b = cnt[7];
      default: b = 1'b0;
    endcase
    return b;
  endfunction

endpackage

// ===== hdl/divider_timer_peripheral.sv =====
// A read or write is executed once; a run of N machine cycles steps the timer N times
// (N saturated to MAX_CYCLES_PER_ITEM, zero steps nothing). One item at a time is taken;
// the datapath steps one machine cycle per clock, so the run length sets the item time.
// Reset: rst_ni is asynchronous and active low; the divider resets to 0xAB00,
// TIMA, TMA, TAC and the pending reload clear, and the controller returns to idle.
`timescale 1ns / 1ps

module divider_timer_peripheral #(
  parameter int MAX_CYCLES_PER_ITEM = 63
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // address [15:0], write_data [23:16], cycle_count [29:24], zero [31:30]
  input  logic [31:0] s_axis_tdata_i,
  // command [1:0]
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // read_data [7:0]
  output logic [7:0]  m_axis_tdata_o,
  // timer_irq [0]
  output logic        m_axis_tuser_o
);

  dtp_pkg::dtp_cmd_t    cmd;
  dtp_pkg::dtp_status_t status;

  dtp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  dtp_datapath #(
    .MAX_CYCLES_PER_ITEM (MAX_CYCLES_PER_ITEM)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .command_i     (s_axis_tuser_i),
    .address_i     (s_axis_tdata_i[15:0]),
    .write_data_i  (s_axis_tdata_i[23:16]),
    .cycle_count_i (s_axis_tdata_i[29:24]),
    .cmd_i         (cmd),
    .status_o      (status),
    .read_data_o   (m_axis_tdata_o),
    .timer_irq_o   (m_axis_tuser_o)
  );

endmodule

// ===== hdl/dtp_ctrl.sv =====
`timescale 1ns / 1ps

module dtp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  dtp_pkg::dtp_status_t status_i,
  output dtp_pkg::dtp_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StExec = 3'b010,
    StFin  = 3'b100
  } dtp_state_e;

  dtp_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = StExec;
        end
      end
      StExec: begin
        if (status_i.is_run) begin
          cmd_o.step = !status_i.cnt_zero;
          if (status_i.cnt_zero || status_i.cnt_one) begin
            state_d = StFin;
          end
        end else begin
          cmd_o.do_bus = 1'b1;
          state_d = StFin;
        end
      end
      StFin: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== hdl/dtp_datapath.sv =====
`timescale 1ns / 1ps

module dtp_datapath #(
  parameter int MAX_CYCLES_PER_ITEM = 63
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [1:0]           command_i,
  input  logic [15:0]          address_i,
  input  logic [7:0]           write_data_i,
  input  logic [5:0]           cycle_count_i,
  input  dtp_pkg::dtp_cmd_t    cmd_i,
  output dtp_pkg::dtp_status_t status_o,
  output logic [7:0]           read_data_o,
  output logic                 timer_irq_o
);

  localparam logic [5:0] MaxCycles = 6'(MAX_CYCLES_PER_ITEM);

  logic [15:0] sys_q, sys_d;
  logic [7:0]  tima_q, tima_d;
  logic [7:0]  tma_q, tma_d;
  logic [2:0]  tac_q, tac_d;
  logic        pend_q, pend_d;

  logic [1:0]  icmd_q;
  logic [15:0] iaddr_q;
  logic [7:0]  idata_q;
  logic [5:0]  cnt_q, cnt_d;
  logic        irq_q, irq_d;
  logic [7:0]  rd_q, rd_d;
  logic [7:0]  out_data_q;
  logic        out_irq_q;

  logic [15:0] sys_step;
  logic [7:0]  tima_step;
  logic        tick_step;
  logic        tick_div;
  logic        tick_tac;

  assign status_o.is_run   = (icmd_q == dtp_pkg::CmdRun);
  assign status_o.cnt_zero = (cnt_q == 6'd0);
  assign status_o.cnt_one  = (cnt_q == 6'd1);
  assign read_data_o       = out_data_q;
  assign timer_irq_o       = out_irq_q;

  assign sys_step  = sys_q + dtp_pkg::SysStep;
  assign tima_step = pend_q ? tma_q : tima_q;
  assign tick_step = tac_q[2] && dtp_pkg::sel_bit(sys_q, tac_q[1:0])
                     && !dtp_pkg::sel_bit(sys_step, tac_q[1:0]);
  assign tick_div  = tac_q[2] && dtp_pkg::sel_bit(sys_q, tac_q[1:0]);
  assign tick_tac  = tac_q[2] && dtp_pkg::sel_bit(sys_q, tac_q[1:0])
                     && !(idata_q[2] && dtp_pkg::sel_bit(sys_q, idata_q[1:0]));

  always_comb begin
    sys_d  = sys_q;
    tima_d = tima_q;
    tma_d  = tma_q;
    tac_d  = tac_q;
    pend_d = pend_q;
    cnt_d  = cnt_q;
    irq_d  = irq_q;
    rd_d   = rd_q;

    if (cmd_i.load_item) begin
      cnt_d = (cycle_count_i > MaxCycles) ? MaxCycles : cycle_count_i;
      irq_d = 1'b0;
      rd_d  = '0;
    end

    if (cmd_i.step) begin
      cnt_d  = cnt_q - 6'd1;
      sys_d  = sys_step;
      tima_d = tima_step;
      pend_d = 1'b0;
      if (pend_q) begin
        irq_d = 1'b1;
      end
      if (tick_step) begin
        tima_d = tima_step + 8'd1;
        if (tima_step == 8'hFF) begin
          pend_d = 1'b1;
        end
      end
    end

    if (cmd_i.do_bus) begin
      if (icmd_q == dtp_pkg::CmdRead) begin
        case (iaddr_q)
          dtp_pkg::AddrDiv:  rd_d = sys_q[15:8];
          dtp_pkg::AddrTima: rd_d = tima_q;
          dtp_pkg::AddrTma:  rd_d = tma_q;
          dtp_pkg::AddrTac:  rd_d = {5'd0, tac_q} | dtp_pkg::TacUpperOnes;
          default:           rd_d = dtp_pkg::UnmappedByte;
        endcase
      end else if (icmd_q == dtp_pkg::CmdWrite) begin
        case (iaddr_q)
          dtp_pkg::AddrDiv: begin
            sys_d = '0;
            if (tick_div) begin
              tima_d = tima_q + 8'd1;
              if (tima_q == 8'hFF) begin
                pend_d = 1'b1;
              end
            end
          end
          dtp_pkg::AddrTima: begin
            pend_d = 1'b0;
            tima_d = idata_q;
          end
          dtp_pkg::AddrTma: begin
            tma_d = idata_q;
          end
          dtp_pkg::AddrTac: begin
            tac_d = idata_q[2:0];
            if (tick_tac) begin
              tima_d = tima_q + 8'd1;
              if (tima_q == 8'hFF) begin
                pend_d = 1'b1;
              end
            end
          end
          default: begin
            sys_d = sys_q;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sys_q  <= dtp_pkg::SysReset;
      tima_q <= '0;
      tma_q  <= '0;
      tac_q  <= '0;
      pend_q <= 1'b0;
    end else begin
      sys_q  <= sys_d;
      tima_q <= tima_d;
      tma_q  <= tma_d;
      tac_q  <= tac_d;
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      icmd_q  <= command_i;
      iaddr_q <= address_i;
      idata_q <= write_data_i;
    end
    cnt_q <= cnt_d;
    irq_q <= irq_d;
    rd_q  <= rd_d;
    if (cmd_i.load_out) begin
      out_data_q <= rd_q;
      out_irq_q  <= irq_q;
    end
  end

endmodule

// ===== hdl/dtp_checker.sv =====
`timescale 1ns / 1ps

module dtp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid_i,
  input logic       s_axis_tready_o,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic       m_axis_tuser_o
);

  // A result waiting on a stalled consumer stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped while stalled");

  // One item at a time: after an accept the input side closes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("second item accepted while one is in work");

  // An interrupt request only comes from a run, which never returns read data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o == 8'h00)
    else $error("interrupt reported together with read data");

  // A result appears only after an item has gone through execution.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> !$past(s_axis_tvalid_i && s_axis_tready_o))
    else $error("result produced in the cycle after accept");

endmodule

bind divider_timer_peripheral dtp_checker u_dtp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam logic [1:0]  CmdNone        = 2'd3;
  localparam int unsigned CycleLimit     = 1000000;
  localparam int          DrainCycles    = 70;
  localparam int          RandomPerPhase = 400;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [5:0]  cycles;
  } bus_item_t;

  typedef struct packed {
    logic [7:0] rd;
    logic       irq;
  } timer_result_t;

  typedef struct packed {
    bus_item_t     item;
    logic          fixed;
    timer_result_t res;
  } stim_row_t;

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [31:0] s_tdata  = '0;
  logic [1:0]  s_tuser  = '0;
  logic        m_tready = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [7:0]  m_axis_tdata_o;
  logic        m_axis_tuser_o;

  logic [15:0] div_count;
  logic [7:0]  tima;
  logic [7:0]  tma;
  logic [2:0]  tac;
  logic        reload_armed;

  timer_result_t expected_results [$];
  timer_result_t oldest;
  stim_row_t     stim_table [$];
  int            tx_idle_pct = 0;
  int            rx_stall_pct = 0;
  int            mismatches = 0;
  int unsigned   cycle_cnt = 0;

  always #10 clk_i = ~clk_i;

  divider_timer_peripheral i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  function automatic logic tap_high(logic [15:0] cnt, logic [2:0] ctl);
    int unsigned pos;
    pos = (ctl[1:0] == 2'd0) ? 9 : 2 * int'(ctl[1:0]) + 1;
    return cnt[pos];
  endfunction

  function automatic void bump_tima();
    if (tima == 8'hFF) begin
      reload_armed = 1'b1;
    end
    tima = tima + 8'd1;
  endfunction

  function automatic void load_div(logic [15:0] value);
    logic was_high;
    was_high = tap_high(div_count, tac);
    div_count = value;
    if (tac[2] && was_high && !tap_high(div_count, tac)) begin
      bump_tima();
    end
  endfunction

  function automatic timer_result_t predict_timer(bus_item_t it);
    timer_result_t res;
    logic          was_live;
    int            k;
    res = '0;
    case (it.cmd)
      dtp_pkg::CmdRun: begin
        for (k = 0; k < it.cycles; k++) begin
          if (reload_armed) begin
            tima = tma;
            res.irq = 1'b1;
            reload_armed = 1'b0;
          end
          load_div(div_count + dtp_pkg::SysStep);
        end
      end
      dtp_pkg::CmdRead: begin
        case (it.addr)
          dtp_pkg::AddrDiv:  res.rd = div_count[15:8];
          dtp_pkg::AddrTima: res.rd = tima;
          dtp_pkg::AddrTma:  res.rd = tma;
          dtp_pkg::AddrTac:  res.rd = dtp_pkg::TacUpperOnes | {5'b00000, tac};
          default:           res.rd = dtp_pkg::UnmappedByte;
        endcase
      end
      dtp_pkg::CmdWrite: begin
        case (it.addr)
          dtp_pkg::AddrDiv: load_div(16'h0000);
          dtp_pkg::AddrTima: begin
            reload_armed = 1'b0;
            tima = it.data;
          end
          dtp_pkg::AddrTma: tma = it.data;
          dtp_pkg::AddrTac: begin
            was_live = tac[2] && tap_high(div_count, tac);
            tac = it.data[2:0];
            if (was_live && !(tac[2] && tap_high(div_count, tac))) begin
              bump_tima();
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic send_item(stim_row_t row);
    timer_result_t res;
    while ($urandom_range(1, 100) <= tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, row.item.cycles, row.item.data, row.item.addr};
    s_tuser  <= row.item.cmd;
    do @(posedge clk_i); while (!s_axis_tready_o);
    res = predict_timer(row.item);
    expected_results.push_back(row.fixed ? row.res : res);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected item, expected none, got read_data %02h timer_irq %b",
                 $time, m_axis_tdata_o, m_axis_tuser_o);
      end else begin
        oldest = expected_results.pop_front();
        if (m_axis_tdata_o !== oldest.rd) begin
          mismatches++;
          $display("%0t: read_data expected %02h got %02h", $time, oldest.rd, m_axis_tdata_o);
        end
        if (m_axis_tuser_o !== oldest.irq) begin
          mismatches++;
          $display("%0t: timer_irq expected %b got %b", $time, oldest.irq, m_axis_tuser_o);
        end
      end
    end
    m_tready <= ($urandom_range(1, 100) > rx_stall_pct);
  end

  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    stim_row_t row;
    int        ph;
    int        n;
    int        r;

    div_count    = dtp_pkg::SysReset;
    tima         = 8'h00;
    tma          = 8'h00;
    tac          = 3'b000;
    reload_armed = 1'b0;

    stim_table.push_back('{'{dtp_pkg::CmdRead, dtp_pkg::AddrDiv, 8'h00, 6'd0},
                           1'b1, '{8'hAB, 1'b0}});
    stim_table.push_back('{'{dtp_pkg::CmdRead, dtp_pkg::AddrTima, 8'h00, 6'd0},
                           1'b1, '{8'h00, 1'b0}});
    stim_table.push_back('{'{dtp_pkg::CmdRead, dtp_pkg::AddrTma, 8'h00, 6'd0},
                           1'b1, '{8'h00, 1'b0}});
    stim_table.push_back('{'{dtp_pkg::CmdRead, dtp_pkg::AddrTac, 8'h00, 6'd0},
                           1'b1, '{8'hF8, 1'b0}});
    stim_table.push_back('{'{dtp_pkg::CmdRead, 16'h0000, 8'h00, 6'd0},
                           1'b1, '{8'hFF, 1'b0}});
    stim_table.push_back('{'{dtp_pkg::CmdRead, 16'hFFFF, 8'hFF, 6'd63},
                           1'b1, '{8'hFF, 1'b0}});
    stim_table.push_back('{'{CmdNone, dtp_pkg::AddrTima, 8'hFF, 6'd63},
                           1'b1, '{8'h00, 1'b0}});
    stim_table.push_back('{'{dtp_pkg::CmdRun, dtp_pkg::AddrDiv, 8'h00, 6'd0},
                           1'b1, '{8'h00, 1'b0}});
    stim_table.push_back('{'{dtp_pkg::CmdRun, 16'h0000, 8'h00, 6'd63},
                           1'b1, '{8'h00, 1'b0}});
    stim_table.push_back('{'{dtp_pkg::CmdWrite, 16'hFF12, 8'hAA, 6'd0},
                           1'b1, '{8'h00, 1'b0}});
    stim_table.push_back('{'{dtp_pkg::CmdWrite, dtp_pkg::AddrTma, 8'hFF, 6'd0},
                           1'b0, '{8'h00, 1'b0}});
    stim_table.push_back('{'{dtp_pkg::CmdWrite, dtp_pkg::AddrTac, 8'hFF, 6'd0},
                           1'b0, '{8'h00, 1'b0}});
    stim_table.push_back('{'{dtp_pkg::CmdRead, dtp_pkg::AddrTac, 8'h00, 6'd0},
                           1'b1, '{8'hFF, 1'b0}});
    stim_table.push_back('{'{dtp_pkg::CmdWrite, dtp_pkg::AddrTac, 8'h05, 6'd0},
                           1'b0, '{8'h00, 1'b0}});
    stim_table.push_back('{'{dtp_pkg::CmdWrite, dtp_pkg::AddrDiv, 8'h00, 6'd0},
                           1'b0, '{8'h00, 1'b0}});
    stim_table.push_back('{'{dtp_pkg::CmdWrite, dtp_pkg::AddrTima, 8'hFF, 6'd0},
                           1'b0, '{8'h00, 1'b0}});
    stim_table.push_back('{'{dtp_pkg::CmdRun, dtp_pkg::AddrDiv, 8'h00, 6'd4},
                           1'b0, '{8'h00, 1'b0}});
    stim_table.push_back('{'{dtp_pkg::CmdWrite, dtp_pkg::AddrTima, 8'h80, 6'd0},
                           1'b0, '{8'h00, 1'b0}});
    stim_table.push_back('{'{dtp_pkg::CmdRun, dtp_pkg::AddrDiv, 8'h00, 6'd1},
                           1'b0, '{8'h00, 1'b0}});
    stim_table.push_back('{'{dtp_pkg::CmdRead, dtp_pkg::AddrTima, 8'h00, 6'd0},
                           1'b0, '{8'h00, 1'b0}});
    stim_table.push_back('{'{dtp_pkg::CmdWrite, dtp_pkg::AddrTima, 8'hFF, 6'd0},
                           1'b0, '{8'h00, 1'b0}});
    stim_table.push_back('{'{dtp_pkg::CmdRun, dtp_pkg::AddrDiv, 8'h00, 6'd4},
                           1'b0, '{8'h00, 1'b0}});
    stim_table.push_back('{'{dtp_pkg::CmdRun, dtp_pkg::AddrDiv, 8'h00, 6'd1},
                           1'b0, '{8'h00, 1'b0}});
    stim_table.push_back('{'{dtp_pkg::CmdRead, dtp_pkg::AddrTima, 8'h00, 6'd0},
                           1'b0, '{8'h00, 1'b0}});
    stim_table.push_back('{'{dtp_pkg::CmdWrite, dtp_pkg::AddrTac, 8'h00, 6'd0},
                           1'b0, '{8'h00, 1'b0}});

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_table[i]) begin
      send_item(stim_table[i]);
    end

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 80; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 80; end
        default: begin tx_idle_pct = 33; rx_stall_pct = 33; end
      endcase
      for (n = 0; n < RandomPerPhase; n++) begin
        row.fixed       = 1'b0;
        row.res         = '0;
        row.item.data   = 8'($urandom_range(0, 255));
        row.item.cycles = 6'($urandom_range(0, 63));
        row.item.addr   = dtp_pkg::AddrDiv + 16'($urandom_range(0, 3));
        if ($urandom_range(0, 99) < 15) begin
          row.item.addr = 16'($urandom_range(0, 65535));
        end
        r = $urandom_range(0, 99);
        if (r < 40) begin
          row.item.cmd = dtp_pkg::CmdRun;
          if ($urandom_range(0, 3) != 0) begin
            row.item.cycles = 6'($urandom_range(0, 8));
          end
        end else if (r < 65) begin
          row.item.cmd = dtp_pkg::CmdRead;
        end else if (r < 97) begin
          row.item.cmd = dtp_pkg::CmdWrite;
          if (row.item.addr == dtp_pkg::AddrTima && $urandom_range(0, 9) < 7) begin
            row.item.data = 8'($urandom_range(8'hF8, 8'hFF));
          end
          if (row.item.addr == dtp_pkg::AddrTac && $urandom_range(0, 9) < 7) begin
            row.item.data[2] = 1'b1;
          end
        end else begin
          row.item.cmd = CmdNone;
        end
        send_item(row);
      end
    end
    s_tvalid <= 1'b0;

    while (expected_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
